// ===== src/rdb_pkg.sv =====
// shared types, widths and constants for the radial distortion and blend pipeline
package rdb_pkg;

    // default number of fraction bits on pixel coordinates
    localparam int COORD_FRAC_BITS_DEFAULT = 4;

    // field widths
    localparam int IN_W       = 17;
    localparam int PREV_W     = 16;
    localparam int CTR_W      = 16;
    localparam int INV_W      = 24;
    localparam int K_W        = 21;
    localparam int OUT_W      = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // internal widths
    localparam int DIFF_W     = IN_W + 1;           // ideal minus center
    localparam int NPROD_W    = DIFF_W + INV_W + 1; // offset times reciprocal focal
    localparam int NORM_W     = NPROD_W + 1;        // rounded normalized value
    localparam int MAG_W      = 31;                 // saturated magnitude
    localparam int POW_W      = 32;                 // r2, r4, r6
    localparam int TERM_W     = K_W + POW_W + 1;    // coefficient times power
    localparam int ACC_W      = 56;                 // radial sum
    localparam int FACTOR_W   = 32;                 // radial factor, Q.16
    localparam int MPROD_W    = DIFF_W + FACTOR_W;  // offset times factor
    localparam int SUM_W      = 36;                 // distorted plus previous

    // saturation limit of the normalized coordinate
    localparam logic [63:0] NORM_MAX = 64'h0000_0000_7FFF_FFFF;

    // pipeline depths
    localparam int NORM_STAGES   = 4;
    localparam int RADIAL_STAGES = 8;
    localparam int BLEND_STAGES  = 3;
    localparam int LATENCY       = NORM_STAGES + RADIAL_STAGES + BLEND_STAGES;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X    = 3'd0,
        REG_CENTER_Y    = 3'd1,
        REG_INV_FOCAL_X = 3'd2,
        REG_INV_FOCAL_Y = 3'd3,
        REG_RADIAL_K1   = 3'd4,
        REG_RADIAL_K2   = 3'd5,
        REG_RADIAL_K3   = 3'd6
    } cfg_index_t;

    // configuration bundle
    typedef struct packed {
        logic        [CTR_W-1:0] center_x;
        logic        [CTR_W-1:0] center_y;
        logic        [INV_W-1:0] inv_focal_x;
        logic        [INV_W-1:0] inv_focal_y;
        logic signed [K_W-1:0]   radial_k1;
        logic signed [K_W-1:0]   radial_k2;
        logic signed [K_W-1:0]   radial_k3;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        center_x:    16'd0,
        center_y:    16'd0,
        inv_focal_x: 24'd16777,
        inv_focal_y: 24'd16777,
        radial_k1:   21'sd0,
        radial_k2:   21'sd0,
        radial_k3:   21'sd0
    };

endpackage

// ===== src/rdb_cfg.sv =====
// configuration register file for lens center, focal reciprocals and radial coefficients
module rdb_cfg
    import rdb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // register write decode, unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (cfg_index_t'(wr_index))
                REG_CENTER_X:    cfg_next.center_x    = wr_data[CTR_W-1:0];
                REG_CENTER_Y:    cfg_next.center_y    = wr_data[CTR_W-1:0];
                REG_INV_FOCAL_X: cfg_next.inv_focal_x = wr_data[INV_W-1:0];
                REG_INV_FOCAL_Y: cfg_next.inv_focal_y = wr_data[INV_W-1:0];
                REG_RADIAL_K1:   cfg_next.radial_k1   = $signed(wr_data[K_W-1:0]);
                REG_RADIAL_K2:   cfg_next.radial_k2   = $signed(wr_data[K_W-1:0]);
                REG_RADIAL_K3:   cfg_next.radial_k3   = $signed(wr_data[K_W-1:0]);
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/rdb_norm.sv =====
// per-axis offset from center and normalization to a saturated magnitude
module rdb_norm
    import rdb_pkg::*;
#(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [IN_W-1:0]   ideal,
    input  logic        [CTR_W-1:0]  center,
    input  logic        [INV_W-1:0]  inv_focal,
    output logic signed [DIFF_W-1:0] d,
    output logic        [MAG_W-1:0]  mag
);

    // half an lsb of the coordinate fraction, zero when there is no fraction
    localparam logic signed [NORM_W-1:0] NORM_HALF =
        NORM_W'((64'd1 << COORD_FRAC_BITS) >> 1);
    localparam logic signed [NORM_W-1:0] POS_MAX = NORM_W'(NORM_MAX);
    localparam logic signed [NORM_W-1:0] NEG_MAX = -POS_MAX;

    logic signed [DIFF_W-1:0]  d1_reg, d1_next;
    logic signed [DIFF_W-1:0]  d2_reg, d3_reg, d4_reg;
    logic signed [NPROD_W-1:0] prod_reg, prod_next;
    logic signed [NORM_W-1:0]  n_reg, n_next;
    logic signed [NORM_W-1:0]  n_neg;
    logic        [MAG_W-1:0]   mag_reg, mag_next;

    // stage 1: offset from principal point
    assign d1_next = $signed({ideal[IN_W-1], ideal}) - $signed({2'b00, center});

    // stage 2: scale by reciprocal focal length
    assign prod_next = d1_reg * $signed({1'b0, inv_focal});

    // stage 3: round away the coordinate fraction
    assign n_next = ($signed({prod_reg[NPROD_W-1], prod_reg}) + NORM_HALF) >>> COORD_FRAC_BITS;

    // stage 4: saturate and take the magnitude
    assign n_neg = -n_reg;

    always_comb
    begin
        if (n_reg > POS_MAX || n_reg < NEG_MAX)
        begin
            mag_next = MAG_W'(NORM_MAX);
        end
        else if (n_reg[NORM_W-1])
        begin
            mag_next = n_neg[MAG_W-1:0];
        end
        else
        begin
            mag_next = n_reg[MAG_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_reg   <= d1_next;
            d2_reg   <= d1_reg;
            prod_reg <= prod_next;
            d3_reg   <= d2_reg;
            n_reg    <= n_next;
            d4_reg   <= d3_reg;
            mag_reg  <= mag_next;
        end
    end

    assign d   = d4_reg;
    assign mag = mag_reg;

endmodule

// ===== src/rdb_radial.sv =====
// radius powers and radial factor 1 + k1 r2 + k2 r4 + k3 r6
module rdb_radial
    import rdb_pkg::*;
(
    input  logic                       clk,
    input  logic                       en,
    input  logic        [MAG_W-1:0]    mag_x,
    input  logic        [MAG_W-1:0]    mag_y,
    input  cfg_t                       cfg,
    output logic signed [FACTOR_W-1:0] factor
);

    localparam logic [64:0] POW_HALF = 65'd1 << 23;
    localparam logic signed [ACC_W-1:0] PART_BIAS =
        (ACC_W'(1) << 40) + (ACC_W'(1) << 23);

    // drop a Q.48 product to Q.24 and saturate to the power width, the caller adds the rounding half
    function automatic logic [POW_W-1:0] sat_pow(input logic [64:0] v);
        logic [40:0] upper;
        upper = v[64:24];
        if (|upper[40:POW_W])
        begin
            sat_pow = '1;
        end
        else
        begin
            sat_pow = upper[POW_W-1:0];
        end
    endfunction

    logic        [2*MAG_W-1:0] sqx_reg, sqx_next;
    logic        [2*MAG_W-1:0] sqy_reg, sqy_next;
    logic        [POW_W-1:0]   r2_reg, r2_next;
    logic        [POW_W-1:0]   r2_3_reg, r2_4_reg;
    logic        [2*POW_W-1:0] p4_reg, p4_next;
    logic        [2*POW_W-1:0] p6_reg, p6_next;
    logic        [POW_W-1:0]   r4_reg, r4_next;
    logic        [POW_W-1:0]   r6_reg, r6_next;
    logic signed [TERM_W-1:0]  t1_reg, t1_next;
    logic signed [TERM_W-1:0]  t1_4_reg, t1_5_reg;
    logic signed [TERM_W-1:0]  t2_reg, t2_next;
    logic signed [TERM_W-1:0]  t3_reg, t3_next;
    logic signed [ACC_W-1:0]   part_reg, part_next;
    logic signed [ACC_W-1:0]   part_7_reg;
    logic signed [ACC_W-1:0]   acc;
    logic signed [FACTOR_W-1:0] factor_reg, factor_next;
    logic        [63:0]        r2_sum;

    // stage 1: squares of the normalized magnitudes
    assign sqx_next = mag_x * mag_x;
    assign sqy_next = mag_y * mag_y;

    // stage 2: r squared
    assign r2_sum  = {2'b00, sqx_reg} + {2'b00, sqy_reg} + 64'(POW_HALF);
    assign r2_next = sat_pow({1'b0, r2_sum});

    // stage 3: r2 squared and first radial term
    assign p4_next = r2_reg * r2_reg;
    assign t1_next = cfg.radial_k1 * $signed({1'b0, r2_reg});

    // stage 4: r4
    assign r4_next = sat_pow({1'b0, p4_reg} + POW_HALF);

    // stage 5: r4 times r2 and second radial term
    assign p6_next = r4_reg * r2_4_reg;
    assign t2_next = cfg.radial_k2 * $signed({1'b0, r4_reg});

    // stage 6: r6 and partial sum with unity and rounding bias
    assign r6_next   = sat_pow({1'b0, p6_reg} + POW_HALF);
    assign part_next = PART_BIAS + ACC_W'(t1_5_reg) + ACC_W'(t2_reg);

    // stage 7: third radial term
    assign t3_next = cfg.radial_k3 * $signed({1'b0, r6_reg});

    // stage 8: final sum, drop to Q.16
    assign acc         = part_7_reg + ACC_W'(t3_reg);
    assign factor_next = acc[ACC_W-1-(ACC_W-24-FACTOR_W) -: FACTOR_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg    <= sqx_next;
            sqy_reg    <= sqy_next;
            r2_reg     <= r2_next;
            p4_reg     <= p4_next;
            t1_reg     <= t1_next;
            r2_3_reg   <= r2_reg;
            r4_reg     <= r4_next;
            t1_4_reg   <= t1_reg;
            r2_4_reg   <= r2_3_reg;
            p6_reg     <= p6_next;
            t2_reg     <= t2_next;
            t1_5_reg   <= t1_4_reg;
            r6_reg     <= r6_next;
            part_reg   <= part_next;
            t3_reg     <= t3_next;
            part_7_reg <= part_reg;
            factor_reg <= factor_next;
        end
    end

    assign factor = factor_reg;

endmodule

// ===== src/rdb_blend.sv =====
// per-axis distortion by the radial factor, average with previous point, saturation
module rdb_blend
    import rdb_pkg::*;
(
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [DIFF_W-1:0]   d,
    input  logic signed [FACTOR_W-1:0] factor,
    input  logic        [PREV_W-1:0]   prev,
    input  logic        [CTR_W-1:0]    center,
    output logic signed [OUT_W-1:0]    blended
);

    localparam int PREV_DELAY = NORM_STAGES + RADIAL_STAGES + 1;
    localparam logic signed [MPROD_W-1:0] M_HALF = MPROD_W'(1) << 15;
    localparam logic signed [SUM_W-1:0]   OUT_HI = SUM_W'(65535);
    localparam logic signed [SUM_W-1:0]   OUT_LO = -SUM_W'(65536);

    logic signed [DIFF_W-1:0]  d_dly_reg [RADIAL_STAGES];
    logic        [PREV_W-1:0]  prev_dly_reg [PREV_DELAY];
    logic signed [MPROD_W-1:0] m_reg, m_next;
    logic signed [MPROD_W-1:0] m_round;
    logic signed [SUM_W-1:0]   s_reg, s_next;
    logic signed [SUM_W-1:0]   h;
    logic signed [OUT_W-1:0]   out_reg, out_next;

    // stage 1: offset times factor
    assign m_next = d_dly_reg[RADIAL_STAGES-1] * factor;

    // stage 2: round to pixels, add center and previous point
    assign m_round = (m_reg + M_HALF) >>> 16;
    assign s_next  = SUM_W'(m_round)
                   + $signed({{(SUM_W-CTR_W){1'b0}}, center})
                   + $signed({{(SUM_W-PREV_W){1'b0}}, prev_dly_reg[PREV_DELAY-1]});

    // stage 3: rounded mean and saturation
    assign h = (s_reg + SUM_W'(1)) >>> 1;

    always_comb
    begin
        if (h > OUT_HI)
        begin
            out_next = OUT_HI[OUT_W-1:0];
        end
        else if (h < OUT_LO)
        begin
            out_next = OUT_LO[OUT_W-1:0];
        end
        else
        begin
            out_next = h[OUT_W-1:0];
        end
    end

    // delay lines align offset and previous point with the factor
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_dly_reg[0]    <= d;
            prev_dly_reg[0] <= prev;
            for (int i = 1; i < RADIAL_STAGES; i++)
            begin
                d_dly_reg[i] <= d_dly_reg[i-1];
            end
            for (int i = 1; i < PREV_DELAY; i++)
            begin
                prev_dly_reg[i] <= prev_dly_reg[i-1];
            end
            m_reg   <= m_next;
            s_reg   <= s_next;
            out_reg <= out_next;
        end
    end

    assign blended = out_reg;

endmodule

// ===== src/radial_distort_and_blend_point_core.sv =====
// throughput: one word per cycle, a new word may enter every cycle while no output word is held
// a stalled output word freezes the whole pipeline through one shared enable
// reset: valid pipeline cleared, configuration returns to defaults, data regs not reset
// top level: radial lens distortion of a point blended with the previous point
module radial_distort_and_blend_point_core
    import rdb_pkg::*;
#(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEFAULT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [IN_W-1:0]  ideal_x,
    input  logic signed [IN_W-1:0]  ideal_y,
    input  logic [PREV_W-1:0]       prev_x,
    input  logic [PREV_W-1:0]       prev_y,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [OUT_W-1:0] blended_x,
    output logic signed [OUT_W-1:0] blended_y,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    cfg_t                       cfg;
    logic                       en;
    logic [LATENCY-1:0]         vld_reg, vld_next;
    logic signed [DIFF_W-1:0]   d_x, d_y;
    logic [MAG_W-1:0]           mag_x, mag_y;
    logic signed [FACTOR_W-1:0] factor;

    // configuration registers, always ready
    assign cfg_ready = 1'b1;

    rdb_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // pipeline advances unless the output word is held
    assign en       = !(vld_reg[LATENCY-1] && out_stall);
    assign in_stall = !en;

    // valid bits travel with the data
    assign vld_next = {vld_reg[LATENCY-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    assign out_valid = vld_reg[LATENCY-1];

    // normalization per axis
    rdb_norm #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_norm_x (
        .clk       (clk),
        .en        (en),
        .ideal     (ideal_x),
        .center    (cfg.center_x),
        .inv_focal (cfg.inv_focal_x),
        .d         (d_x),
        .mag       (mag_x)
    );

    rdb_norm #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_norm_y (
        .clk       (clk),
        .en        (en),
        .ideal     (ideal_y),
        .center    (cfg.center_y),
        .inv_focal (cfg.inv_focal_y),
        .d         (d_y),
        .mag       (mag_y)
    );

    // shared radial factor
    rdb_radial u_radial (
        .clk    (clk),
        .en     (en),
        .mag_x  (mag_x),
        .mag_y  (mag_y),
        .cfg    (cfg),
        .factor (factor)
    );

    // distortion and blend per axis
    rdb_blend u_blend_x (
        .clk     (clk),
        .en      (en),
        .d       (d_x),
        .factor  (factor),
        .prev    (prev_x),
        .center  (cfg.center_x),
        .blended (blended_x)
    );

    rdb_blend u_blend_y (
        .clk     (clk),
        .en      (en),
        .d       (d_y),
        .factor  (factor),
        .prev    (prev_y),
        .center  (cfg.center_y),
        .blended (blended_y)
    );

    // input is held back only by a held output word
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held output word");

    // an accepted word enters the first pipeline stage
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> vld_reg[0])
        else $error("accepted word missing from pipeline");

    // a frozen pipeline keeps its valid bits
    a_freeze_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(vld_reg))
        else $error("valid pipeline moved while frozen");

endmodule
